// ----- rtl/assert_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros shared by the FM operator waveform RTL
// Clocked on clk_i; the checked form is disabled while rst_ni is low.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check at every rising edge outside reset
`define FMOW_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// check at every rising edge, reset included
`define FMOW_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// ----- rtl/fmow_pkg.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// fmow_pkg
// Types, codes and constant ROM contents of the FM operator waveform block.
// ---------------------------------------------------------------------------
package fmow_pkg;

  // Geometry of the two ROMs
  localparam int LOGSIN_DEPTH = 512;
  localparam int EXP_DEPTH    = 8192;
  localparam int LOGSIN_HALF  = LOGSIN_DEPTH / 2;
  localparam int EXP_FRAC_N   = 256;

  localparam int PHASE_W  = 10;
  localparam int ATTEN_W  = 12;
  localparam int SAMPLE_W = 14;
  localparam int LS_IDX_W = $clog2(LOGSIN_DEPTH);
  localparam int LS_Q_W   = $clog2(LOGSIN_HALF);
  localparam int EXP_IDX_W = $clog2(EXP_DEPTH);
  localparam int FRAC_IDX_W = $clog2(EXP_FRAC_N);
  localparam int WHOLE_W  = EXP_IDX_W - FRAC_IDX_W;
  localparam int LS_VAL_W = 12;
  localparam int FRAC_W   = 11;
  localparam int MAG_W    = 13;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 12;

  localparam logic [ATTEN_W-1:0] OPN_ATTEN_MAX_RST = 12'd4092;
  localparam logic [ATTEN_W-1:0] OPL_ATTEN_MAX_RST = 12'd4095;
  localparam logic [MAG_W-1:0]   MAG_MAX           = 13'd8168;

  localparam real PI_R  = 3.14159265358979323846;
  localparam real LN2_R = 0.69314718055994530942;

  typedef enum logic {
    MODE_OPN = 1'b0,
    MODE_OPL = 1'b1
  } chip_mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CHIP_MODE     = 2'd0,
    CFG_OPN_ATTEN_MAX = 2'd1,
    CFG_OPL_ATTEN_MAX = 2'd2
  } cfg_idx_e;

  typedef enum logic [2:0] {
    WAVE_FULL    = 3'd0,
    WAVE_HALF    = 3'd1,
    WAVE_ABS     = 3'd2,
    WAVE_QUARTER = 3'd3,
    WAVE_ALT     = 3'd4,
    WAVE_CAMEL   = 3'd5,
    WAVE_SQUARE  = 3'd6,
    WAVE_LOGSAW  = 3'd7
  } wave_e;

  // Control that travels with each request down the pipe
  typedef struct packed {
    logic valid;
    logic zero;
    logic neg;
  } fmow_ctl_t;

  // Stage one payload: where the exponent index comes from
  typedef struct packed {
    logic                  use_sine;
    logic [LS_IDX_W-1:0]   ls_idx;
    logic [ATTEN_W-1:0]    base;
    logic [ATTEN_W-1:0]    atten;
  } fmow_s1_t;

  typedef logic [LS_VAL_W-1:0] logsin_tab_t [LOGSIN_HALF];
  typedef logic [FRAC_W-1:0]   exp_tab_t    [EXP_FRAC_N];

  // First quarter of the log-sine wave, 4.8 attenuation, rounded half up
  function automatic logsin_tab_t build_logsin();
    logsin_tab_t tab;
    real         x;
    for (int i = 0; i < LOGSIN_HALF; i++) begin
      x = -$ln($sin(real'(2 * i + 1) * PI_R / 1024.0)) / LN2_R * 256.0;
      tab[i] = LS_VAL_W'($rtoi(x + 0.5));
    end
    return tab;
  endfunction

  // Fractional octave of the exponential, 2048 * 2^-((k+1)/256)
  function automatic exp_tab_t build_exp();
    exp_tab_t tab;
    real      x;
    for (int k = 0; k < EXP_FRAC_N; k++) begin
      x = 2048.0 * $pow(2.0, -(real'(k) + 1.0) / 256.0);
      tab[k] = FRAC_W'($rtoi(x + 0.5));
    end
    return tab;
  endfunction

  localparam logsin_tab_t LOGSIN_ROM = build_logsin();
  localparam exp_tab_t    EXP_ROM    = build_exp();

endpackage
`default_nettype wire

// ----- rtl/fmow_decode.sv -----
`default_nettype none
`include "assert_macros.svh"
// ---------------------------------------------------------------------------
// fmow_decode
// Stage one: phase modulation, attenuation clamp and waveform decode.
// ---------------------------------------------------------------------------
module fmow_decode (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            valid_i,
  input  wire logic [fmow_pkg::PHASE_W-1:0]    phase_i,
  input  wire logic signed [fmow_pkg::PHASE_W-1:0] mod_offset_i,
  input  wire logic [fmow_pkg::ATTEN_W-1:0]    atten_i,
  input  wire logic [2:0]                      wave_sel_i,
  input  wire fmow_pkg::chip_mode_e            chip_mode_i,
  input  wire logic [fmow_pkg::ATTEN_W-1:0]    opn_atten_max_i,
  input  wire logic [fmow_pkg::ATTEN_W-1:0]    opl_atten_max_i,
  output fmow_pkg::fmow_s1_t                   s1_o,
  output fmow_pkg::fmow_ctl_t                  ctl_o
);
  import fmow_pkg::*;

  logic [PHASE_W-1:0] opn_ph;
  logic [ATTEN_W-1:0] att_max;
  fmow_s1_t           s1_d, s1_q;
  fmow_ctl_t          ctl_d, ctl_q;
  wave_e              wave;

  // Clamp the attenuation to the active mode's ceiling
  assign att_max = (chip_mode_i == MODE_OPL) ? opl_atten_max_i : opn_atten_max_i;
  assign opn_ph  = phase_i + $unsigned(mod_offset_i);
  assign wave    = wave_e'(wave_sel_i);

  // Decode the log-sine index or direct exponent base per waveform
  always_comb begin
    s1_d.use_sine = 1'b1;
    s1_d.ls_idx   = phase_i[LS_IDX_W-1:0];
    s1_d.base     = '0;
    s1_d.atten    = (atten_i > att_max) ? att_max : atten_i;
    ctl_d.valid   = valid_i;
    ctl_d.zero    = 1'b0;
    ctl_d.neg     = 1'b0;
    if (chip_mode_i == MODE_OPN) begin
      s1_d.ls_idx = opn_ph[LS_IDX_W-1:0];
      ctl_d.neg   = opn_ph[9];
    end else begin
      unique case (wave)
        WAVE_FULL: begin
          ctl_d.neg = phase_i[9];
        end
        WAVE_HALF: begin
          ctl_d.zero = phase_i[9];
        end
        WAVE_ABS: begin
        end
        WAVE_QUARTER: begin
          s1_d.ls_idx = {1'b0, phase_i[7:0]};
          ctl_d.zero  = phase_i[8];
        end
        WAVE_ALT: begin
          s1_d.ls_idx = {phase_i[7:0], 1'b0};
          ctl_d.zero  = phase_i[9];
          ctl_d.neg   = phase_i[8];
        end
        WAVE_CAMEL: begin
          s1_d.ls_idx = {phase_i[7:0], 1'b0};
          ctl_d.zero  = phase_i[9];
        end
        WAVE_SQUARE: begin
          s1_d.use_sine = 1'b0;
          ctl_d.neg     = phase_i[9];
        end
        WAVE_LOGSAW: begin
          s1_d.use_sine = 1'b0;
          s1_d.base     = phase_i[9] ? {~phase_i[8:0], 3'b000} : {phase_i[8:0], 3'b000};
          ctl_d.neg     = phase_i[9];
        end
      endcase
    end
  end

  // Advance the valid bit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else begin
      ctl_q <= ctl_d;
    end
  end

  // Hold the payload
  always_ff @(posedge clk_i) begin
    s1_q <= s1_d;
  end

  assign s1_o  = s1_q;
  assign ctl_o = ctl_q;

  `FMOW_ASSERT(a_atten_clamped, ctl_q.valid |-> (s1_q.atten <= $past(att_max)), "attenuation above clamp")

endmodule
`default_nettype wire

// ----- rtl/fmow_logsin.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// fmow_logsin
// Stage two: log-sine ROM lookup and exponent index sum.
// ---------------------------------------------------------------------------
module fmow_logsin (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire fmow_pkg::fmow_s1_t             s1_i,
  input  wire fmow_pkg::fmow_ctl_t            ctl_i,
  output logic [fmow_pkg::EXP_IDX_W-1:0]      exp_idx_o,
  output fmow_pkg::fmow_ctl_t                 ctl_o
);
  import fmow_pkg::*;

  logic [LS_Q_W-1:0]    q_idx;
  logic [LS_VAL_W-1:0]  ls_val;
  logic [ATTEN_W-1:0]   base;
  logic [EXP_IDX_W-1:0] exp_idx_d, exp_idx_q;
  fmow_ctl_t            ctl_q;

  // Mirror the second quarter onto the stored first quarter
  assign q_idx  = s1_i.ls_idx[LS_IDX_W-1] ? ~s1_i.ls_idx[LS_Q_W-1:0] : s1_i.ls_idx[LS_Q_W-1:0];
  assign ls_val = LOGSIN_ROM[q_idx];
  assign base   = s1_i.use_sine ? ls_val : s1_i.base;
  assign exp_idx_d = EXP_IDX_W'({1'b0, base} + {1'b0, s1_i.atten});

  // Advance the valid bit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else begin
      ctl_q <= ctl_i;
    end
  end

  // Hold the exponent index
  always_ff @(posedge clk_i) begin
    exp_idx_q <= exp_idx_d;
  end

  assign exp_idx_o = exp_idx_q;
  assign ctl_o     = ctl_q;

endmodule
`default_nettype wire

// ----- rtl/fmow_exp.sv -----
`default_nettype none
`include "assert_macros.svh"
// ---------------------------------------------------------------------------
// fmow_exp
// Stage three: exponential ROM lookup and octave shift to a magnitude.
// ---------------------------------------------------------------------------
module fmow_exp (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic [fmow_pkg::EXP_IDX_W-1:0] exp_idx_i,
  input  wire fmow_pkg::fmow_ctl_t            ctl_i,
  output logic [fmow_pkg::MAG_W-1:0]          mag_o,
  output fmow_pkg::fmow_ctl_t                 ctl_o
);
  import fmow_pkg::*;

  logic [FRAC_W-1:0]  frac;
  logic [WHOLE_W-1:0] whole;
  logic [MAG_W-1:0]   mag_d, mag_q;
  fmow_ctl_t          ctl_q;

  assign frac  = EXP_ROM[exp_idx_i[FRAC_IDX_W-1:0]];
  assign whole = exp_idx_i[EXP_IDX_W-1:FRAC_IDX_W];

  // Shift left for the two top octaves, right for the rest
  always_comb begin
    case (whole)
      WHOLE_W'(0): mag_d = {frac, 2'b00};
      WHOLE_W'(1): mag_d = {1'b0, frac, 1'b0};
      default:     mag_d = {2'b00, frac} >> (whole - WHOLE_W'(2));
    endcase
  end

  // Advance the valid bit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else begin
      ctl_q <= ctl_i;
    end
  end

  // Hold the magnitude
  always_ff @(posedge clk_i) begin
    mag_q <= mag_d;
  end

  assign mag_o = mag_q;
  assign ctl_o = ctl_q;

  `FMOW_ASSERT(a_mag_range, ctl_q.valid |-> (mag_q <= MAG_MAX), "magnitude out of range")

endmodule
`default_nettype wire

// ----- rtl/fm_operator_waveform_top.sv -----
`default_nettype none
`include "assert_macros.svh"
// ---------------------------------------------------------------------------
// fm_operator_waveform_top
// FM operator output by log-sine and exponential lookup, OPN and OPL modes.
// ---------------------------------------------------------------------------
// Takes one request per clock: busy_o never rises, so every cycle with
// start_i high is a new request. Each request gives exactly one sample
// on sample_o, marked by a single-cycle valid_o strobe, in request order.
// The four register stages are decode and clamp, log-sine ROM and index
// sum, exponential ROM and shift, then sign. The receiver cannot stall
// the pipe; samples must be taken on the strobe.
// Configuration writes are always ready and should be made while no
// request is in flight.
module fm_operator_waveform_top (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 start_i,
  output logic                                      busy_o,
  input  wire logic [fmow_pkg::PHASE_W-1:0]         phase_i,
  input  wire logic signed [fmow_pkg::PHASE_W-1:0]  mod_offset_i,
  input  wire logic [fmow_pkg::ATTEN_W-1:0]         atten_i,
  input  wire logic [2:0]                           wave_sel_i,
  output logic                                      valid_o,
  output logic signed [fmow_pkg::SAMPLE_W-1:0]      sample_o,
  input  wire logic                                 cfg_valid_i,
  output logic                                      cfg_ready_o,
  input  wire logic [fmow_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  wire logic [fmow_pkg::CFG_DATA_W-1:0]      cfg_data_i
);
  import fmow_pkg::*;

  chip_mode_e           chip_mode_q;
  logic [ATTEN_W-1:0]   opn_max_q, opl_max_q;
  logic                 accept;
  fmow_s1_t             s1;
  fmow_ctl_t            ctl1, ctl2, ctl3;
  logic [EXP_IDX_W-1:0] exp_idx;
  logic [MAG_W-1:0]     mag;
  logic signed [SAMPLE_W-1:0] mag_s, sample_d, sample_q;
  logic                 valid_q;

  assign busy_o      = 1'b0;
  assign cfg_ready_o = 1'b1;
  assign accept      = start_i & ~busy_o;

  // Take configuration writes; drop those beyond the register list
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chip_mode_q <= MODE_OPN;
      opn_max_q   <= OPN_ATTEN_MAX_RST;
      opl_max_q   <= OPL_ATTEN_MAX_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_CHIP_MODE:     chip_mode_q <= chip_mode_e'(cfg_data_i[0]);
        CFG_OPN_ATTEN_MAX: opn_max_q   <= cfg_data_i[ATTEN_W-1:0];
        CFG_OPL_ATTEN_MAX: opl_max_q   <= cfg_data_i[ATTEN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  fmow_decode u_decode (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .valid_i         (accept),
    .phase_i         (phase_i),
    .mod_offset_i    (mod_offset_i),
    .atten_i         (atten_i),
    .wave_sel_i      (wave_sel_i),
    .chip_mode_i     (chip_mode_q),
    .opn_atten_max_i (opn_max_q),
    .opl_atten_max_i (opl_max_q),
    .s1_o            (s1),
    .ctl_o           (ctl1)
  );

  fmow_logsin u_logsin (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s1_i      (s1),
    .ctl_i     (ctl1),
    .exp_idx_o (exp_idx),
    .ctl_o     (ctl2)
  );

  fmow_exp u_exp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .exp_idx_i (exp_idx),
    .ctl_i     (ctl2),
    .mag_o     (mag),
    .ctl_o     (ctl3)
  );

  // Apply sign or force zero
  assign mag_s    = $signed({1'b0, mag});
  assign sample_d = ctl3.zero ? '0 : (ctl3.neg ? -mag_s : mag_s);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= ctl3.valid;
    end
  end

  // Hold the output sample
  always_ff @(posedge clk_i) begin
    sample_q <= sample_d;
  end

  assign valid_o  = valid_q;
  assign sample_o = sample_q;

  `FMOW_ASSERT(a_sample_range,
    valid_o |-> (sample_o <= 14'sd8168 && sample_o >= -14'sd8168), "sample out of range")
  `FMOW_ASSERT(a_zero_out,
    (ctl3.valid && ctl3.zero) |=> (valid_o && sample_o == '0), "zeroed request gave non-zero sample")
  `FMOW_ASSERT_ALWAYS(a_reset_quiet, !rst_ni |=> !valid_o, "strobe during reset")

endmodule
`default_nettype wire

// ----- sim/fm_operator_waveform_top_tb.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fm_operator_waveform_top_tb
// Self-checking bench for the FM operator waveform block. A directed table
// covers the extremes of every field, both modes and all eight OPL
// waveforms. Random requests follow, under several clamp settings. Every
// sample is compared with a predictor that rebuilds both ROMs in exact
// Q60 integer arithmetic.
// ---------------------------------------------------------------------------
module fm_operator_waveform_top_tb;
  import fmow_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 2'd3;
  localparam bit [63:0] Q_ONE = 64'h1000_0000_0000_0000;
  localparam bit [63:0] PI_Q  = 64'h3243_F6A8_885A_308D;
  localparam bit [63:0] LN2_Q = 64'h0B17_217F_7D1C_F79A;
  localparam int N_DIR  = 27;
  localparam int N_SETS = 8;
  localparam int N_PER_SET = 82;

  typedef struct {
    chip_mode_e         mode;
    logic [11:0]        opn_max;
    logic [11:0]        opl_max;
    logic [9:0]         phase;
    logic signed [9:0]  mod;
    logic [11:0]        atten;
    wave_e              wave;
    bit                 typed;
    logic signed [13:0] want;
  } dir_row_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  start_i = 1'b0;
  logic                  busy_o;
  logic [9:0]            phase_i = '0;
  logic signed [9:0]     mod_offset_i = '0;
  logic [11:0]           atten_i = '0;
  logic [2:0]            wave_sel_i = '0;
  logic                  valid_o;
  logic signed [13:0]    sample_o;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  // Predictor copy of the registers and ROMs
  chip_mode_e  mode_cur    = MODE_OPN;
  logic [11:0] opn_max_cur = 12'd4092;
  logic [11:0] opl_max_cur = 12'd4095;
  int          lsin_tab  [LOGSIN_DEPTH];
  int          efrac_tab [EXP_FRAC_N];

  logic signed [13:0] sample_want_q [$];
  logic signed [13:0] want_now;
  int                 fail_cnt = 0;
  int                 burst_left = 0;
  dir_row_t           dir_tab [N_DIR];

  fm_operator_waveform_top u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .busy_o       (busy_o),
    .phase_i      (phase_i),
    .mod_offset_i (mod_offset_i),
    .atten_i      (atten_i),
    .wave_sel_i   (wave_sel_i),
    .valid_o      (valid_o),
    .sample_o     (sample_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  always #6 clk_i = ~clk_i;

  // (a * b) >> 60 on Q60 operands, kept to 64 bits
  function automatic bit [63:0] q60_mul(bit [63:0] a, bit [63:0] b);
    bit [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[123:60];
  endfunction

  // Attenuation of one quarter-wave entry: sine series, then squaring log2
  function automatic int lsin_calc(int i);
    bit [63:0] x, x2, s, t, m, v, acc, r;
    int        e;
    x   = (PI_Q >> 10) * 64'(2 * i + 1);
    x2  = q60_mul(x, x);
    s   = x;
    t   = x;
    acc = '0;
    e   = 0;
    for (int k = 1; k < 40 && t != 0; k++) begin
      t = q60_mul(t, x2) / (64'(2 * k) * 64'(2 * k + 1));
      if (k % 2 == 1) s = s - t;
      else s = s + t;
    end
    m = s;
    while (m < Q_ONE && e < 60) begin
      m = m << 1;
      e++;
    end
    for (int b = 0; b < 32; b++) begin
      m   = q60_mul(m, m);
      acc = acc << 1;
      if (m >= 2 * Q_ONE) begin
        acc[0] = 1'b1;
        m = m >> 1;
      end
    end
    v = (64'(e) << 32) - acc;
    r = (v + (64'd1 << 23)) >> 24;
    return int'(r[15:0]);
  endfunction

  // One fractional-octave entry of the exponential, by series of e^-y
  function automatic int efrac_calc(int k);
    bit [63:0] y, sum, t, r;
    y   = (LN2_Q >> 8) * 64'(k + 1);
    sum = Q_ONE;
    t   = Q_ONE;
    for (int n = 1; n < 60 && t != 0; n++) begin
      t = q60_mul(t, y) / 64'(n);
      if (n % 2 == 1) sum = sum - t;
      else sum = sum + t;
    end
    r = (sum + (64'd1 << 48)) >> 49;
    return int'(r[15:0]);
  endfunction

  task automatic build_tables();
    for (int i = 0; i < LOGSIN_HALF; i++) begin
      lsin_tab[i] = lsin_calc(i);
      lsin_tab[LOGSIN_DEPTH - 1 - i] = lsin_tab[i];
    end
    for (int k = 0; k < EXP_FRAC_N; k++) efrac_tab[k] = efrac_calc(k);
  endtask

  function automatic int expo_mag(int idx);
    int i, f, whole;
    i     = idx & (EXP_DEPTH - 1);
    f     = efrac_tab[i & 255];
    whole = i >> 8;
    if (whole < 2) return f << (2 - whole);
    return f >> (whole - 2);
  endfunction

  function automatic int sine_level(int idx, int att);
    return expo_mag(lsin_tab[idx & (LOGSIN_DEPTH - 1)] + att);
  endfunction

  // Expected sample of one request under the current register copy
  function automatic logic signed [13:0] predict_sample(logic [9:0] ph,
      logic [9:0] mod, logic [11:0] att, wave_e ws);
    logic [9:0] p;
    int         a, mag;
    bit         neg;
    mag = 0;
    neg = 1'b0;
    if (mode_cur == MODE_OPN) begin
      p   = ph + mod;
      a   = (att > opn_max_cur) ? int'(opn_max_cur) : int'(att);
      mag = sine_level(int'(p[8:0]), a);
      neg = p[9];
    end else begin
      a = (att > opl_max_cur) ? int'(opl_max_cur) : int'(att);
      case (ws)
        WAVE_FULL: begin
          mag = sine_level(int'(ph[8:0]), a);
          neg = ph[9];
        end
        WAVE_HALF: if (!ph[9]) mag = sine_level(int'(ph[8:0]), a);
        WAVE_ABS: mag = sine_level(int'(ph[8:0]), a);
        WAVE_QUARTER: if (!ph[8]) mag = sine_level(int'(ph[7:0]), a);
        WAVE_ALT: begin
          if (!ph[9]) begin
            mag = sine_level(int'(ph[7:0]) << 1, a);
            neg = ph[8];
          end
        end
        WAVE_CAMEL: if (!ph[9]) mag = sine_level(int'(ph[7:0]) << 1, a);
        WAVE_SQUARE: begin
          mag = expo_mag(a);
          neg = ph[9];
        end
        default: begin
          // log-saw: falling half mirrors the index
          if (ph[9]) begin
            mag = expo_mag((int'(ph[8:0] ^ 9'h1FF) << 3) + a);
            neg = 1'b1;
          end else begin
            mag = expo_mag((int'(ph[8:0]) << 3) + a);
          end
        end
      endcase
    end
    return neg ? 14'(-mag) : 14'(mag);
  endfunction

  // Hold the request until accepted, then record its expected sample
  task automatic issue_request(logic [9:0] ph, logic [9:0] mod, logic [11:0] att,
      wave_e ws, bit typed, logic signed [13:0] want);
    @(negedge clk_i);
    start_i      <= 1'b1;
    phase_i      <= ph;
    mod_offset_i <= mod;
    atten_i      <= att;
    wave_sel_i   <= ws;
    do @(posedge clk_i); while (busy_o);
    sample_want_q.push_back(typed ? want : predict_sample(ph, mod, att, ws));
  endtask

  // Send in bursts, dropping start for a random gap between them
  task automatic pace_sender();
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
      if (gap != 0) begin
        @(negedge clk_i);
        start_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
  endtask

  // Stop sending and wait for every outstanding sample
  task automatic drain_pipe();
    @(negedge clk_i);
    start_i <= 1'b0;
    while (sample_want_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_CHIP_MODE:     mode_cur = chip_mode_e'(data[0]);
      CFG_OPN_ATTEN_MAX: opn_max_cur = data;
      CFG_OPL_ATTEN_MAX: opl_max_cur = data;
      default: ;
    endcase
  endtask

  // Idle the pipe, then write all registers and the unused index
  task automatic cfg_apply(chip_mode_e mode, logic [11:0] opn_max, logic [11:0] opl_max);
    drain_pipe();
    cfg_write(CFG_CHIP_MODE, {11'($urandom), mode});
    cfg_write(CFG_OPN_ATTEN_MAX, opn_max);
    cfg_write(CFG_OPL_ATTEN_MAX, opl_max);
    cfg_write(CFG_IDX_SPARE, 12'($urandom));
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Compare each strobed sample with the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && valid_o) begin
      if (sample_want_q.size() == 0) begin
        $display("%0t: sample %0d with none expected", $time, sample_o);
        fail_cnt++;
      end else begin
        want_now = sample_want_q.pop_front();
        if (sample_o !== want_now) begin
          $display("%0t: sample mismatch: expected %0d, got %0d",
                   $time, want_now, sample_o);
          fail_cnt++;
        end
      end
    end
  end

  initial begin
    #2_000_000;
    $display("** fm_operator_waveform_top: FAILED **");
    $finish;
  end

  initial begin : stim
    logic [11:0] opn_max, opl_max, att;
    dir_row_t    row;

    dir_tab = '{
      // reset setting, OPN: quadrant peaks and offset wrap
      '{MODE_OPN, 12'd4092, 12'd4095, 10'h100, 10'sd0,    12'd0,   WAVE_FULL,   1'b1, 14'sd8168},
      '{MODE_OPN, 12'd4092, 12'd4095, 10'h300, 10'sd0,    12'd0,   WAVE_FULL,   1'b1, -14'sd8168},
      '{MODE_OPN, 12'd4092, 12'd4095, 10'h000, 10'sd256,  12'd0,   WAVE_FULL,   1'b1, 14'sd8168},
      '{MODE_OPN, 12'd4092, 12'd4095, 10'h200, -10'sd256, 12'd0,   WAVE_FULL,   1'b1, 14'sd8168},
      '{MODE_OPN, 12'd4092, 12'd4095, 10'h000, -10'sd256, 12'd0,   WAVE_FULL,   1'b1, -14'sd8168},
      '{MODE_OPN, 12'd4092, 12'd4095, 10'h3FF, 10'sd511,  12'd4095, WAVE_FULL,  1'b0, 14'sd0},
      '{MODE_OPN, 12'd4092, 12'd4095, 10'h000, 10'h200,   12'd0,   WAVE_FULL,   1'b0, 14'sd0},
      '{MODE_OPN, 12'd4092, 12'd4095, 10'h2AB, 10'sd341,  12'h5A5, WAVE_LOGSAW, 1'b0, 14'sd0},
      // OPN clamp at zero lifts any attenuation to full scale
      '{MODE_OPN, 12'd0,    12'd4095, 10'h100, 10'sd0,    12'd4095, WAVE_FULL,  1'b1, 14'sd8168},
      // OPL, every waveform at its peaks and zero regions
      '{MODE_OPL, 12'd4092, 12'd4095, 10'h100, 10'h200,   12'd0,   WAVE_FULL,    1'b1, 14'sd8168},
      '{MODE_OPL, 12'd4092, 12'd4095, 10'h300, 10'sd511,  12'd0,   WAVE_FULL,    1'b1, -14'sd8168},
      '{MODE_OPL, 12'd4092, 12'd4095, 10'h300, 10'sd0,    12'd0,   WAVE_HALF,    1'b1, 14'sd0},
      '{MODE_OPL, 12'd4092, 12'd4095, 10'h300, 10'sd0,    12'd0,   WAVE_ABS,     1'b1, 14'sd8168},
      '{MODE_OPL, 12'd4092, 12'd4095, 10'h0FF, 10'sd0,    12'd0,   WAVE_QUARTER, 1'b1, 14'sd8168},
      '{MODE_OPL, 12'd4092, 12'd4095, 10'h100, 10'sd0,    12'd0,   WAVE_QUARTER, 1'b1, 14'sd0},
      '{MODE_OPL, 12'd4092, 12'd4095, 10'h180, 10'sd0,    12'd0,   WAVE_ALT,     1'b1, -14'sd8168},
      '{MODE_OPL, 12'd4092, 12'd4095, 10'h280, 10'sd0,    12'd0,   WAVE_ALT,     1'b1, 14'sd0},
      '{MODE_OPL, 12'd4092, 12'd4095, 10'h180, 10'sd0,    12'd0,   WAVE_CAMEL,   1'b1, 14'sd8168},
      '{MODE_OPL, 12'd4092, 12'd4095, 10'h380, 10'sd0,    12'd0,   WAVE_CAMEL,   1'b1, 14'sd0},
      '{MODE_OPL, 12'd4092, 12'd4095, 10'h000, 10'sd0,    12'd0,   WAVE_SQUARE,  1'b1, 14'sd8168},
      '{MODE_OPL, 12'd4092, 12'd4095, 10'h3FF, 10'sd0,    12'd0,   WAVE_SQUARE,  1'b1, -14'sd8168},
      '{MODE_OPL, 12'd4092, 12'd4095, 10'h000, 10'sd0,    12'd0,   WAVE_LOGSAW,  1'b1, 14'sd8168},
      '{MODE_OPL, 12'd4092, 12'd4095, 10'h3FF, 10'sd0,    12'd0,   WAVE_LOGSAW,  1'b1, -14'sd8168},
      // negative half at full attenuation: negated zero stays zero
      '{MODE_OPL, 12'd4092, 12'd4095, 10'h200, 10'sd0,    12'd4095, WAVE_SQUARE, 1'b1, 14'sd0},
      '{MODE_OPL, 12'd4092, 12'd4095, 10'h1C3, 10'sd0,    12'h05A, WAVE_LOGSAW,  1'b0, 14'sd0},
      '{MODE_OPL, 12'd4092, 12'd4095, 10'h2AA, 10'sd0,    12'h3FF, WAVE_ABS,     1'b0, 14'sd0},
      // OPL clamp at zero
      '{MODE_OPL, 12'd4092, 12'd0,    10'h000, 10'sd0,    12'd4095, WAVE_SQUARE, 1'b1, 14'sd8168}
    };

    build_tables();
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed table, reconfiguring only where the row asks for it
    for (int r = 0; r < N_DIR; r++) begin
      row = dir_tab[r];
      if (row.mode != mode_cur || row.opn_max != opn_max_cur || row.opl_max != opl_max_cur)
        cfg_apply(row.mode, row.opn_max, row.opl_max);
      pace_sender();
      issue_request(row.phase, row.mod, row.atten, row.wave, row.typed, row.want);
    end

    // Random requests under alternating modes and several clamp settings
    for (int set_no = 0; set_no < N_SETS; set_no++) begin
      case (set_no)
        0, 1: begin opn_max = 12'd4092; opl_max = 12'd4095; end
        2, 3: begin opn_max = 12'd4095; opl_max = 12'd4095; end
        4, 5: begin opn_max = 12'd0;    opl_max = 12'd0;    end
        default: begin opn_max = 12'($urandom); opl_max = 12'($urandom); end
      endcase
      cfg_apply(chip_mode_e'(set_no[0]), opn_max, opl_max);
      for (int j = 0; j < N_PER_SET; j++) begin
        pace_sender();
        if ((set_no == 3 && j == 40) || $urandom_range(0, 79) == 0) drain_pipe();
        case ($urandom_range(0, 3))
          0, 1: att = 12'($urandom_range(0, 767));
          2: att = 12'($urandom);
          default: att = 12'($urandom_range(4080, 4095));
        endcase
        issue_request(10'($urandom), 10'($urandom), att, wave_e'($urandom_range(0, 7)),
                      1'b0, 14'sd0);
      end
    end

    drain_pipe();
    repeat (8) @(posedge clk_i);
    if (fail_cnt == 0) $display("** fm_operator_waveform_top: PASSED **");
    else $display("** fm_operator_waveform_top: FAILED **");
    $finish;
  end

endmodule
